>>> src/fbf_pkg.sv
// shared types and constants of the page framebuffer flush engine
package fbf_pkg;

   localparam int MAX_WIDTH_DEF = 128;
   localparam int MAX_PAGES_DEF = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_PX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAGES      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COL_OFFSET = 2'd2;

   localparam logic [7:0] WIDTH_PX_RST   = 8'd128;
   localparam logic [3:0] PAGES_RST      = 4'd8;
   localparam logic [6:0] COL_OFFSET_RST = 7'd0;

   localparam logic [1:0] ACT_DRAW  = 2'd0;
   localparam logic [1:0] ACT_FILL  = 2'd1;
   localparam logic [1:0] ACT_FLUSH = 2'd2;

   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_HI = 8'h10;
   localparam logic [7:0] FILL_OFF   = 8'h00;
   localparam logic [7:0] FILL_ON    = 8'hFF;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] pixel_x;
      logic [5:0] pixel_y;
      logic       pixel_color;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
   } rsp_type;

endpackage

>>> src/page_framebuffer_flush_engine.sv
// top level: register file, limit clamping, sequencer and frame store
// an in-range draw is busy while the store byte is read and then written back; fill is busy while
//   width*pages store bytes are written, one store byte written per cycle
// flush word: a command word shows in the cycle after accept, a data word follows one store
//   read in S_FLUSH_RD; a command word leaves busy low, a data word holds it high for its read
// reset: synchronous; the store is swept to zero, all MAX_WIDTH*MAX_PAGES bytes, with busy high
// results are strobed for one cycle on rsp_valid; the receiver cannot stall
module page_framebuffer_flush_engine #(
   parameter int MAX_WIDTH = fbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_PAGES = fbf_pkg::MAX_PAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  fbf_pkg::req_type                  req_item,
   output logic                              rsp_valid,
   output fbf_pkg::rsp_type                  rsp_item,
   input  logic                              csr_we,
   input  logic [fbf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fbf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH * MAX_PAGES);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = $clog2(MAX_PAGES + 1);

   logic [7:0]    width_px_ff;
   logic [3:0]    pages_ff;
   logic [6:0]    col_offset_ff;
   logic [WW-1:0] eff_width;
   logic [PW-1:0] eff_pages;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_px_ff   <= fbf_pkg::WIDTH_PX_RST;
         pages_ff      <= fbf_pkg::PAGES_RST;
         col_offset_ff <= fbf_pkg::COL_OFFSET_RST;
      end else if (csr_we) begin
         case (csr_index)
            fbf_pkg::REG_WIDTH_PX:   width_px_ff   <= csr_wdata;
            fbf_pkg::REG_PAGES:      pages_ff      <= csr_wdata[3:0];
            fbf_pkg::REG_COL_OFFSET: col_offset_ff <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_px_ff == 8'd0) begin
         eff_width = WW'(1);
      end else if (10'(width_px_ff) > 10'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(width_px_ff);
      end
      if (pages_ff == 4'd0) begin
         eff_pages = PW'(1);
      end else if (6'(pages_ff) > 6'(MAX_PAGES)) begin
         eff_pages = PW'(MAX_PAGES);
      end else begin
         eff_pages = PW'(pages_ff);
      end
   end

   fbf_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_PAGES (MAX_PAGES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .eff_width   (eff_width),
      .eff_pages   (eff_pages),
      .col_offset  (col_offset_ff),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   fbf_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_PAGES (MAX_PAGES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

>>> src/fbf_store.sv
// frame store: one write port, one read port with registered read data
module fbf_store #(
   parameter int MAX_WIDTH = fbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_PAGES = fbf_pkg::MAX_PAGES_DEF
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [$clog2(MAX_WIDTH*MAX_PAGES)-1:0]      wr_addr,
   input  logic [7:0]                                  wr_data,
   input  logic                                        rd_en,
   input  logic [$clog2(MAX_WIDTH*MAX_PAGES)-1:0]      rd_addr,
   output logic [7:0]                                  rd_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_PAGES;

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fbf_ctrl.sv
// sequencer: clear sweep, pixel read-modify-write, fill sweep and flush stepping
module fbf_ctrl #(
   parameter int MAX_WIDTH = fbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_PAGES = fbf_pkg::MAX_PAGES_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  fbf_pkg::req_type                            req_item,
   output logic                                        rsp_valid,
   output fbf_pkg::rsp_type                            rsp_item,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]              eff_width,
   input  logic [$clog2(MAX_PAGES+1)-1:0]              eff_pages,
   input  logic [6:0]                                  col_offset,
   output logic                                        mem_wr_en,
   output logic [$clog2(MAX_WIDTH*MAX_PAGES)-1:0]      mem_wr_addr,
   output logic [7:0]                                  mem_wr_data,
   output logic                                        mem_rd_en,
   output logic [$clog2(MAX_WIDTH*MAX_PAGES)-1:0]      mem_rd_addr,
   input  logic [7:0]                                  mem_rd_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int PW    = $clog2(MAX_PAGES + 1);
   localparam int PIW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int POSW  = $clog2(MAX_WIDTH + 3);
   localparam int CLW   = $clog2(MAX_WIDTH);
   localparam int CW    = (WW > 7) ? WW : 7;
   localparam int PGW   = (PW > 3) ? PW : 3;

   localparam int POS_PAGE   = 0;
   localparam int POS_COL_LO = 1;
   localparam int POS_COL_HI = 2;

   typedef enum logic [1:0] {
      S_WALK,
      S_IDLE,
      S_DRAW_RD,
      S_FLUSH_RD
   } state_type;

   state_type        state_ff, state_in;
   logic             flush_busy_ff, flush_busy_in;
   logic [PIW-1:0]   flush_page_ff, flush_page_in;
   logic [POSW-1:0]  flush_pos_ff, flush_pos_in;
   logic [AW-1:0]    walk_cnt_ff, walk_cnt_in;
   logic [AW-1:0]    walk_last_ff, walk_last_in;
   logic [7:0]       walk_byte_ff, walk_byte_in;
   logic             rsp_valid_ff, rsp_valid_in;

   fbf_pkg::rsp_type rsp_item_ff, rsp_item_in;
   logic [AW-1:0]    draw_addr_ff, draw_addr_in;
   logic [2:0]       draw_bit_ff, draw_bit_in;
   logic             draw_color_ff, draw_color_in;
   logic             pend_last_ff, pend_last_in;

   logic [2:0]       dr_pg;
   logic             dr_in_range;
   logic [3+WW-1:0]  dr_prod;
   logic [AW-1:0]    dr_addr;
   logic [WW+PW-1:0] fill_prod;

   logic [PIW-1:0]   fl_page0, fl_page;
   logic [POSW-1:0]  fl_pos0, fl_col_raw;
   logic [CLW-1:0]   fl_col;
   logic             fl_col_end, fl_last_page;
   logic [PIW+WW-1:0] fl_prod;
   logic [AW-1:0]    fl_addr;
   logic [7:0]       draw_mask;

   always_comb begin
      dr_pg       = req_item.pixel_y[5:3];
      dr_in_range = (CW'(req_item.pixel_x) < CW'(eff_width)) && (PGW'(dr_pg) < PGW'(eff_pages));
      dr_prod     = (3+WW)'(dr_pg) * (3+WW)'(eff_width);
      dr_addr     = AW'(dr_prod) + AW'(req_item.pixel_x);
      fill_prod   = (WW+PW)'(eff_width) * (WW+PW)'(eff_pages);

      fl_page0 = flush_busy_ff ? flush_page_ff : '0;
      fl_pos0  = flush_busy_ff ? flush_pos_ff : '0;
      fl_page  = (PW'(fl_page0) >= eff_pages) ? PIW'(eff_pages - PW'(1)) : fl_page0;
      fl_col_raw = fl_pos0 - POSW'(3);
      fl_col_end = fl_col_raw >= (POSW'(eff_width) - POSW'(1));
      fl_col     = (fl_col_raw >= POSW'(eff_width)) ? CLW'(eff_width - WW'(1))
                                                    : CLW'(fl_col_raw);
      fl_prod    = (PIW+WW)'(fl_page) * (PIW+WW)'(eff_width);
      fl_addr    = AW'(fl_prod) + AW'(fl_col);
      fl_last_page = (PW'(fl_page) + PW'(1)) >= eff_pages;
      draw_mask  = 8'(1) << draw_bit_ff;
   end

   always_comb begin
      state_in      = state_ff;
      flush_busy_in = flush_busy_ff;
      flush_page_in = flush_page_ff;
      flush_pos_in  = flush_pos_ff;
      walk_cnt_in   = walk_cnt_ff;
      walk_last_in  = walk_last_ff;
      walk_byte_in  = walk_byte_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      draw_addr_in  = draw_addr_ff;
      draw_bit_in   = draw_bit_ff;
      draw_color_in = draw_color_ff;
      pend_last_in  = pend_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = walk_cnt_ff;
      mem_wr_data   = walk_byte_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = fl_addr;
      case (state_ff)
         S_WALK: begin
            mem_wr_en = 1'b1;
            if (walk_cnt_ff == walk_last_ff) begin
               state_in = S_IDLE;
            end else begin
               walk_cnt_in = walk_cnt_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               case (req_item.action)
                  fbf_pkg::ACT_DRAW: begin
                     if (dr_in_range) begin
                        mem_rd_en     = 1'b1;
                        mem_rd_addr   = dr_addr;
                        draw_addr_in  = dr_addr;
                        draw_bit_in   = req_item.pixel_y[2:0];
                        draw_color_in = req_item.pixel_color;
                        state_in      = S_DRAW_RD;
                     end
                  end
                  fbf_pkg::ACT_FILL: begin
                     walk_cnt_in  = '0;
                     walk_last_in = AW'(fill_prod - (WW+PW)'(1));
                     walk_byte_in = req_item.pixel_color ? fbf_pkg::FILL_ON
                                                         : fbf_pkg::FILL_OFF;
                     state_in     = S_WALK;
                  end
                  fbf_pkg::ACT_FLUSH: begin
                     flush_busy_in = 1'b1;
                     flush_page_in = fl_page;
                     rsp_item_in.is_data = 1'b0;
                     rsp_item_in.last    = 1'b0;
                     if (fl_pos0 == POSW'(POS_PAGE)) begin
                        rsp_valid_in         = 1'b1;
                        rsp_item_in.out_byte = fbf_pkg::CMD_PAGE + 8'(fl_page);
                        flush_pos_in         = POSW'(POS_COL_LO);
                     end else if (fl_pos0 == POSW'(POS_COL_LO)) begin
                        rsp_valid_in         = 1'b1;
                        rsp_item_in.out_byte = {4'h0, col_offset[3:0]};
                        flush_pos_in         = POSW'(POS_COL_HI);
                     end else if (fl_pos0 == POSW'(POS_COL_HI)) begin
                        rsp_valid_in         = 1'b1;
                        rsp_item_in.out_byte = fbf_pkg::CMD_COL_HI + {5'b0, col_offset[6:4]};
                        flush_pos_in         = POSW'(POS_COL_HI + 1);
                     end else begin
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = fl_addr;
                        pend_last_in = 1'b0;
                        state_in     = S_FLUSH_RD;
                        if (fl_col_end) begin
                           flush_pos_in = '0;
                           if (fl_last_page) begin
                              pend_last_in  = 1'b1;
                              flush_busy_in = 1'b0;
                              flush_page_in = '0;
                           end else begin
                              flush_page_in = fl_page + PIW'(1);
                           end
                        end else begin
                           flush_pos_in = fl_pos0 + POSW'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRAW_RD: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = draw_addr_ff;
            mem_wr_data = draw_color_ff ? (mem_rd_data | draw_mask)
                                        : (mem_rd_data & ~draw_mask);
            state_in    = S_IDLE;
         end
         S_FLUSH_RD: begin
            rsp_valid_in         = 1'b1;
            rsp_item_in.out_byte = mem_rd_data;
            rsp_item_in.is_data  = 1'b1;
            rsp_item_in.last     = pend_last_ff;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_WALK;
         flush_busy_ff <= 1'b0;
         flush_page_ff <= '0;
         flush_pos_ff  <= '0;
         walk_cnt_ff   <= '0;
         walk_last_ff  <= AW'(DEPTH - 1);
         walk_byte_ff  <= fbf_pkg::FILL_OFF;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flush_busy_ff <= flush_busy_in;
         flush_page_ff <= flush_page_in;
         flush_pos_ff  <= flush_pos_in;
         walk_cnt_ff   <= walk_cnt_in;
         walk_last_ff  <= walk_last_in;
         walk_byte_ff  <= walk_byte_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff   <= rsp_item_in;
      draw_addr_ff  <= draw_addr_in;
      draw_bit_ff   <= draw_bit_in;
      draw_color_ff <= draw_color_in;
      pend_last_ff  <= pend_last_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // reads and writes never share a cycle, so no forwarding is needed
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("store read and write in the same cycle");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.last |-> rsp_item_ff.is_data)
      else $error("last marked on a command word");

   a_flush_rd_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH_RD |=> rsp_valid_ff && rsp_item_ff.is_data)
      else $error("data read did not produce a data word");

   a_idle_flush_pos: assert property (@(posedge clock) disable iff (reset)
      !flush_busy_ff |-> flush_pos_ff == '0 && flush_page_ff == '0)
      else $error("flush position held while no refresh runs");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> walk_cnt_ff <= walk_last_ff)
      else $error("sweep ran past its last entry");

endmodule
